// File: src/imhq_pkg.sv
// ----------------------------------------------------------------------------
// imhq_pkg: shared constants and types for the indexed min-heap queue
// Holds the heap geometry, operation and status codes.
// ----------------------------------------------------------------------------
package imhq_pkg;
  localparam int CAPACITY   = 1024;
  localparam int KEY_WIDTH  = 32;
  localparam int ITEM_SPACE = 1024;
  localparam int SLOT_W     = $clog2(CAPACITY);
  localparam int ITEM_W     = 10;
  localparam int CNT_W      = SLOT_W + 1;

  localparam logic [1:0] OP_PUSH = 2'd0;
  localparam logic [1:0] OP_POP  = 2'd1;
  localparam logic [1:0] OP_UPD  = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;
  localparam logic [1:0] ST_NOTHELD = 2'd3;

  typedef logic [KEY_WIDTH-1:0] key_t;
  typedef logic [SLOT_W-1:0]    slot_t;
  typedef logic [ITEM_W-1:0]    item_t;
  typedef logic [CNT_W-1:0]     cnt_t;
endpackage

// File: src/indexed_min_heap_queue.sv
// ----------------------------------------------------------------------------
// indexed_min_heap_queue: indexed binary min-heap with decrease/increase key
// Push, pop and re-key through slot and position memories.
// ----------------------------------------------------------------------------
// A word runs through lookup, sift-up (parent read and compare per level), then
// sift-down (left and right child reads and compare per level) if it did not rise,
// write-back and top read; pop first reads the root and the last slot.
// One word at a time: the next word is accepted once the result is taken.
// Reset clears all ITEM_SPACE held flags before in_ready rises.
module indexed_min_heap_queue
  import imhq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_operation,
  input  logic [9:0]  in_item,
  input  logic [31:0] in_key,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [9:0]  out_top_item,
  output logic [31:0] out_top_key,
  output logic [10:0] out_count,
  output logic        out_is_empty,
  output logic [1:0]  out_status
);
  localparam logic [3:0] S_CLR = 4'd0, S_IDLE = 4'd1, S_LOOK = 4'd2,
    S_POPR = 4'd3, S_POPL = 4'd4, S_POPM = 4'd5, S_UPR = 4'd6, S_UPC = 4'd7,
    S_DNR = 4'd8, S_DNL = 4'd9, S_DNC = 4'd10, S_WR = 4'd11, S_TOPR = 4'd12,
    S_TOPW = 4'd13, S_OUT = 4'd14;

  // memories
  item_t slot_item_m [CAPACITY];
  key_t  slot_key_m  [CAPACITY];
  slot_t pos_m       [ITEM_SPACE];
  logic  held_m      [ITEM_SPACE];

  logic [3:0] state_r;
  logic [1:0] op_r;
  item_t      item_r;
  key_t       key_r;
  cnt_t       cnt_r;
  logic [1:0] status_r;
  slot_t      pos_r;
  logic       moved_r;
  item_t      cur_item_r;
  key_t       cur_key_r;
  item_t      l_item_r;
  key_t       l_key_r;
  logic       l_lt_r;
  item_t      rd_item_r;
  key_t       rd_key_r;
  slot_t      rd_pos_r;
  logic       rd_held_r;
  item_t      clr_r;
  item_t      top_item_r;
  key_t       top_key_r;

  // memory port controls driven per state
  slot_t s_raddr, s_waddr;
  logic  s_we;
  item_t s_wi;
  key_t  s_wk;
  item_t i_raddr, p_waddr, h_waddr;
  logic  p_we, h_we, h_wd;
  slot_t p_wd;

  slot_t up_par, lc, rc;
  cnt_t  cnt_dec;
  logic [CNT_W-1:0] l_idx;
  logic [CNT_W:0]   r_idx;
  logic  l_in, r_in, r_win;

  assign up_par  = (pos_r - slot_t'(1)) >> 1;
  assign l_idx   = {pos_r, 1'b1};
  assign r_idx   = {1'b0, pos_r, 1'b0} + (CNT_W + 1)'(2);
  assign lc      = l_idx[SLOT_W-1:0];
  assign rc      = r_idx[SLOT_W-1:0];
  assign l_in    = l_idx < cnt_r;
  assign r_in    = r_idx < {1'b0, cnt_r};
  assign cnt_dec = cnt_r - cnt_t'(1);
  // right wins only if strictly below the smaller of parent and left
  assign r_win   = r_in && (rd_key_r < (l_lt_r ? l_key_r : cur_key_r));

  always_ff @(posedge clk) begin
    rd_item_r <= slot_item_m[s_raddr];
    rd_key_r  <= slot_key_m[s_raddr];
    rd_pos_r  <= pos_m[i_raddr];
    rd_held_r <= held_m[i_raddr];
    if (s_we) begin
      slot_item_m[s_waddr] <= s_wi;
      slot_key_m[s_waddr]  <= s_wk;
    end
    if (p_we) pos_m[p_waddr] <= p_wd;
    if (h_we) held_m[h_waddr] <= h_wd;
  end

  always_comb begin
    s_raddr = pos_r;
    s_we = 1'b0; s_waddr = pos_r; s_wi = cur_item_r; s_wk = cur_key_r;
    i_raddr = item_r;
    p_we = 1'b0; p_waddr = cur_item_r; p_wd = pos_r;
    h_we = 1'b0; h_waddr = item_r; h_wd = 1'b0;
    case (state_r)
      S_CLR: begin
        h_we = 1'b1; h_waddr = clr_r;
      end
      S_IDLE: i_raddr = in_item;
      S_LOOK: begin
        if (op_r == OP_PUSH && !rd_held_r && cnt_r != cnt_t'(CAPACITY)) begin
          h_we = 1'b1; h_wd = 1'b1;
        end
      end
      S_POPR: s_raddr = '0;
      S_POPL: begin
        // drop the root item, fetch the last slot
        h_we = 1'b1; h_waddr = rd_item_r;
        s_raddr = cnt_dec[SLOT_W-1:0];
      end
      S_UPR: s_raddr = up_par;
      S_UPC: begin
        if (cur_key_r < rd_key_r) begin
          s_we = 1'b1; s_wi = rd_item_r; s_wk = rd_key_r;
          p_we = 1'b1; p_waddr = rd_item_r;
        end
      end
      S_DNR: s_raddr = lc;
      S_DNL: s_raddr = rc;
      S_DNC: begin
        if (r_win) begin
          s_we = 1'b1; s_wi = rd_item_r; s_wk = rd_key_r;
          p_we = 1'b1; p_waddr = rd_item_r;
        end else if (l_lt_r) begin
          s_we = 1'b1; s_wi = l_item_r; s_wk = l_key_r;
          p_we = 1'b1; p_waddr = l_item_r;
        end
      end
      S_WR: begin
        s_we = 1'b1; p_we = 1'b1;
      end
      S_TOPR: s_raddr = '0;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r <= '0;
      cnt_r <= '0;
      op_r <= OP_PUSH;
      item_r <= '0;
      key_r <= '0;
      status_r <= ST_OK;
      pos_r <= '0;
      moved_r <= 1'b0;
      cur_item_r <= '0;
      cur_key_r <= '0;
      l_item_r <= '0;
      l_key_r <= '0;
      l_lt_r <= 1'b0;
      top_item_r <= '0;
      top_key_r <= '0;
    end else begin
      case (state_r)
        S_CLR: begin
          clr_r <= clr_r + item_t'(1);
          if (clr_r == item_t'(ITEM_SPACE - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) begin
            op_r <= in_operation; item_r <= in_item; key_r <= in_key;
            status_r <= ST_OK;
            state_r <= S_LOOK;
          end
        end
        S_LOOK: begin
          cur_key_r <= key_r; cur_item_r <= item_r;
          moved_r <= 1'b0;
          if (rd_held_r && (op_r == OP_PUSH || op_r == OP_UPD)) begin
            // re-key in place: rise, then sink if it did not move
            pos_r <= rd_pos_r;
            state_r <= S_UPR;
          end else if (op_r == OP_PUSH) begin
            if (cnt_r == cnt_t'(CAPACITY)) begin
              status_r <= ST_FULL; state_r <= S_TOPR;
            end else begin
              pos_r <= cnt_r[SLOT_W-1:0];
              cnt_r <= cnt_r + cnt_t'(1);
              state_r <= S_UPR;
            end
          end else if (op_r == OP_POP) begin
            if (cnt_r == '0) begin
              status_r <= ST_EMPTY; state_r <= S_TOPR;
            end else begin
              state_r <= S_POPR;
            end
          end else if (op_r == OP_UPD) begin
            status_r <= ST_NOTHELD; state_r <= S_TOPR;
          end else begin
            state_r <= S_TOPR;
          end
        end
        S_POPR: state_r <= S_POPL;
        S_POPL: state_r <= S_POPM;
        S_POPM: begin
          cur_item_r <= rd_item_r; cur_key_r <= rd_key_r;
          cnt_r <= cnt_dec;
          pos_r <= '0;
          state_r <= (cnt_dec == '0) ? S_TOPR : S_DNR;
        end
        S_UPR: begin
          if (pos_r == '0) state_r <= moved_r ? S_WR : S_DNR;
          else state_r <= S_UPC;
        end
        S_UPC: begin
          if (cur_key_r < rd_key_r) begin
            pos_r <= up_par;
            moved_r <= 1'b1;
            state_r <= S_UPR;
          end else begin
            state_r <= moved_r ? S_WR : S_DNR;
          end
        end
        S_DNR: state_r <= l_in ? S_DNL : S_WR;
        S_DNL: begin
          l_item_r <= rd_item_r; l_key_r <= rd_key_r;
          l_lt_r <= rd_key_r < cur_key_r;
          state_r <= S_DNC;
        end
        S_DNC: begin
          if (r_win) begin
            pos_r <= rc; state_r <= S_DNR;
          end else if (l_lt_r) begin
            pos_r <= lc; state_r <= S_DNR;
          end else begin
            state_r <= S_WR;
          end
        end
        S_WR: state_r <= S_TOPR;
        S_TOPR: state_r <= S_TOPW;
        S_TOPW: begin
          top_item_r <= (cnt_r == '0) ? '0 : rd_item_r;
          top_key_r <= (cnt_r == '0) ? '0 : rd_key_r;
          state_r <= S_OUT;
        end
        S_OUT: if (out_ready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready     = (state_r == S_IDLE);
  assign out_valid    = (state_r == S_OUT);
  assign out_top_item = top_item_r;
  assign out_top_key  = top_key_r;
  assign out_count    = cnt_r;
  assign out_is_empty = (cnt_r == '0);
  assign out_status   = status_r;
endmodule

// File: verif/indexed_min_heap_queue_test.sv
// ----------------------------------------------------------------------------
// indexed_min_heap_queue_test: self-checking bench for the indexed min-heap
// Drives push, pop, update and reserved-opcode words with random idling, keeps
// its own heap model and compares every result word field by field in order.
// ----------------------------------------------------------------------------
module indexed_min_heap_queue_test;
  import imhq_pkg::*;

  localparam logic [1:0] OP_RSVD = 2'd3;

  typedef struct packed {
    logic [1:0]  op;
    logic [9:0]  item;
    logic [31:0] key;
  } req_t;

  typedef struct packed {
    logic [9:0]  top_item;
    logic [31:0] top_key;
    logic [10:0] count;
    logic        is_empty;
    logic [1:0]  status;
  } rsp_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_operation = '0;
  logic [9:0]  in_item = '0;
  logic [31:0] in_key = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [9:0]  out_top_item;
  logic [31:0] out_top_key;
  logic [10:0] out_count;
  logic        out_is_empty;
  logic [1:0]  out_status;

  indexed_min_heap_queue DUT (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // heap model
  logic [9:0]  hp_item [CAPACITY];
  logic [31:0] hp_key  [CAPACITY];
  int          pos_of  [ITEM_SPACE];
  bit          held    [ITEM_SPACE];
  int          fill;

  req_t pending_words[$];
  rsp_t expected_tops[$];
  int   errors = 0;
  int   n_sent = 0;
  int   n_checked = 0;
  int   n_full = 0, n_empty = 0, n_notheld = 0;
  int   cycles = 0;
  bit   noidle = 1'b0;
  bit   hold_out = 1'b0;
  bit   hold_done = 1'b0;
  int   hold_left = 0;

  function automatic void swap_slot(int a, int b);
    logic [9:0]  ti;
    logic [31:0] tk;
    ti = hp_item[a]; tk = hp_key[a];
    hp_item[a] = hp_item[b]; hp_key[a] = hp_key[b];
    hp_item[b] = ti; hp_key[b] = tk;
    pos_of[hp_item[a]] = a;
    pos_of[hp_item[b]] = b;
  endfunction

  function automatic void sift_up(int p);
    int up;
    while (p > 0 && p < fill) begin
      up = (p - 1) >> 1;
      if (hp_key[p] < hp_key[up]) begin
        swap_slot(p, up);
        p = up;
      end else break;
    end
  endfunction

  function automatic void sink_slot(int p);
    int best;
    while (p < fill) begin
      best = p;
      if (2*p+1 < fill && hp_key[2*p+1] < hp_key[best]) best = 2*p+1;
      if (2*p+2 < fill && hp_key[2*p+2] < hp_key[best]) best = 2*p+2;
      if (best == p) break;
      swap_slot(p, best);
      p = best;
    end
  endfunction

  function automatic void rekey(int it, logic [31:0] k);
    int s;
    s = pos_of[it];
    if (s < fill) begin
      hp_key[s] = k;
      sift_up(s);
      sink_slot(s);
    end
  endfunction

  function automatic rsp_t heap_apply(req_t w);
    rsp_t r;
    r = '0;
    r.status = ST_OK;
    if (w.op == OP_PUSH) begin
      if (held[w.item]) rekey(w.item, w.key);
      else if (fill >= CAPACITY) r.status = ST_FULL;
      else begin
        hp_item[fill] = w.item;
        hp_key[fill] = w.key;
        pos_of[w.item] = fill;
        held[w.item] = 1'b1;
        fill++;
        sift_up(fill - 1);
      end
    end else if (w.op == OP_POP) begin
      if (fill == 0) r.status = ST_EMPTY;
      else begin
        held[hp_item[0]] = 1'b0;
        hp_item[0] = hp_item[fill-1];
        hp_key[0] = hp_key[fill-1];
        fill--;
        if (fill > 0) begin
          pos_of[hp_item[0]] = 0;
          sink_slot(0);
        end
      end
    end else if (w.op == OP_UPD) begin
      if (!held[w.item]) r.status = ST_NOTHELD;
      else rekey(w.item, w.key);
    end
    if (fill > 0) begin
      r.top_item = hp_item[0];
      r.top_key = hp_key[0];
    end
    r.count = fill[10:0];
    r.is_empty = (fill == 0);
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst_n && !(in_valid && !in_ready)) begin
      if (in_valid && in_ready) begin
        rsp_t x;
        x = heap_apply({in_operation, in_item, in_key});
        expected_tops.insert(expected_tops.size(), x);
        n_sent++;
      end
      if (pending_words.size() > 0 && (noidle || $urandom_range(99) >= 29)) begin
        req_t w;
        w = pending_words.pop_front();
        in_valid <= 1'b1;
        in_operation <= w.op;
        in_item <= w.item;
        in_key <= w.key;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver hold-off counter
  always @(posedge clk) begin
    if (hold_out && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= 600;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        rsp_t e;
        if (expected_tops.size() == 0) begin
          $error("result word with nothing expected");
          errors++;
        end else begin
          e = expected_tops.pop_front();
          n_checked++;
          if (e.status == ST_FULL) n_full++;
          if (e.status == ST_EMPTY) n_empty++;
          if (e.status == ST_NOTHELD) n_notheld++;
          if (out_top_item !== e.top_item) begin
            $error("top_item exp %0d got %0d", e.top_item, out_top_item); errors++;
          end
          if (out_top_key !== e.top_key) begin
            $error("top_key exp %0h got %0h", e.top_key, out_top_key); errors++;
          end
          if (out_count !== e.count) begin
            $error("count exp %0d got %0d", e.count, out_count); errors++;
          end
          if (out_is_empty !== e.is_empty) begin
            $error("is_empty exp %0d got %0d", e.is_empty, out_is_empty); errors++;
          end
          if (out_status !== e.status) begin
            $error("status exp %0d got %0d", e.status, out_status); errors++;
          end
        end
      end
      out_ready <= (hold_left == 0) && (noidle || $urandom_range(99) >= 29);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > 2000000) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic add_word(logic [1:0] op, logic [9:0] it, logic [31:0] k);
    req_t w;
    w.op = op;
    w.item = it;
    w.key = k;
    pending_words.insert(pending_words.size(), w);
  endtask

  task automatic drain();
    while (pending_words.size() > 0 || in_valid || expected_tops.size() > 0)
      @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // random word; mostly push/pop/update of items likely held
  task automatic add_random(int span);
    int r;
    r = $urandom_range(99);
    if (r < 45) add_word(OP_PUSH, 10'($urandom_range(span)), $urandom);
    else if (r < 75) add_word(OP_POP, 10'($urandom), $urandom);
    else if (r < 97) add_word(OP_UPD, 10'($urandom_range(span)),
                              ($urandom_range(3) == 0) ? $urandom_range(8) : $urandom);
    else add_word(OP_RSVD, 10'($urandom), $urandom);
  endtask

  initial begin
    fill = 0;
    foreach (held[i]) held[i] = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty pop, unheld update, extremes, ties, duplicate push, unknown opcode
    add_word(OP_POP, 10'd0, 32'd0);
    add_word(OP_UPD, 10'd5, 32'd1);
    add_word(OP_PUSH, 10'd1023, 32'hFFFF_FFFF);
    add_word(OP_PUSH, 10'd0, 32'd0);
    add_word(OP_PUSH, 10'd7, 32'd0);
    add_word(OP_PUSH, 10'd8, 32'd100);
    add_word(OP_PUSH, 10'd9, 32'd100);
    add_word(OP_PUSH, 10'd8, 32'd50);
    add_word(OP_UPD, 10'd1023, 32'd1);
    add_word(OP_UPD, 10'd0, 32'hFFFF_FFFF);
    add_word(OP_RSVD, 10'h3FF, 32'hFFFF_FFFF);
    add_word(OP_UPD, 10'd7, 32'hAAAA_5555);
    repeat (7) add_word(OP_POP, 10'd0, 32'd0);
    drain();

    // fill to capacity with no idling, then re-key a held item on the full heap
    noidle = 1'b1;
    for (int i = 0; i < CAPACITY; i++) add_word(OP_PUSH, 10'(i), $urandom);
    add_word(OP_PUSH, 10'd1023, 32'd3);
    drain();
    noidle = 1'b0;
    add_word(OP_UPD, 10'd512, 32'd0);
    for (int i = 0; i < 40; i++) add_word(OP_POP, 10'd0, 32'd0);
    drain();
    // receiver stall while sender keeps offering
    hold_out = 1'b1;
    for (int i = 0; i < 120; i++) add_random(1023);
    drain();

    $display("Sent %0d words, checked %0d, deep sifts on a full heap covered",
             n_sent, n_checked);
    $display("Rejects seen: %0d full, %0d empty, %0d not held",
             n_full, n_empty, n_notheld);
    if (errors == 0 && expected_tops.size() == 0 && n_checked == n_sent)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end
endmodule
